// ===== rtl/lrs_pkg.sv =====
// Shared types, constants and helpers for the S-record text encoder.
`timescale 1ns / 1ps

package lrs_pkg;

   // Command queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Character index within one command (up to 22 characters)
   localparam int IDX_W = 5;

   // Load file record types and limits
   localparam logic [7:0]  TYPE_DATA  = 8'h02;
   localparam logic [7:0]  TYPE_START = 8'h16;
   localparam logic [7:0]  MAX_COUNT  = 8'd252;
   localparam logic [7:0]  ADDR_BYTES = 8'h03;
   localparam logic [23:0] POS_MAX    = 24'hFFFFFF;
   localparam logic [15:0] NREC_MAX   = 16'hFFFF;
   localparam logic [7:0]  NULL_S9_CK = 8'hFC;

   // Result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_TYPE   = 2'd1;
   localparam logic [1:0] ST_END_IN_REC = 2'd2;
   localparam logic [1:0] ST_COUNT_BIG  = 2'd3;

   // ASCII characters
   localparam logic [6:0] CH_S   = 7'h53;
   localparam logic [6:0] CH_1   = 7'h31;
   localparam logic [6:0] CH_5   = 7'h35;
   localparam logic [6:0] CH_9   = 7'h39;
   localparam logic [6:0] CH_NL  = 7'h0A;
   localparam logic [6:0] CH_NUL = 7'h00;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_COUNT,
      PH_DATA,
      PH_STOPPED,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      CMD_S9,
      CMD_S1,
      CMD_DATA,
      CMD_END,
      CMD_ERR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  word;
      logic [7:0]   val8;
      logic [7:0]   cksum;
      logic         fin;
      logic [1:0]   status;
      logic [7:0]   bad_type;
      logic [23:0]  offset;
   } cmd_type;

   function automatic logic [6:0] hex_char(input logic [3:0] n);
      logic [6:0] ext;
      ext = {3'b000, n};
      return (n < 4'd10) ? (7'h30 + ext) : (7'h37 + ext);
   endfunction

endpackage

// ===== rtl/lrs_front.sv =====
// Front end: parses load file bytes and issues text commands to the queue.
`timescale 1ns / 1ps

module lrs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_input,
   input  logic              q_full,
   output logic              push,
   output lrs_pkg::cmd_type  push_cmd
);

   lrs_pkg::phase_type phase_ff, phase_in;
   logic        kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] nrec_ff, nrec_in;
   logic        s9seen_ff, s9seen_in;
   logic [23:0] pos_ff, pos_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  s_b;
   logic [7:0]  s_b3;
   logic [7:0]  cnt3;
   logic [15:0] nrec_inc;
   logic [7:0]  end_sum;

   assign accept   = req_valid && !q_full;
   assign b        = req_in_byte;
   assign s_b      = sum_ff + b;
   assign s_b3     = s_b + lrs_pkg::ADDR_BYTES;
   assign cnt3     = b + lrs_pkg::ADDR_BYTES;
   assign nrec_inc = (nrec_ff == lrs_pkg::NREC_MAX) ? nrec_ff : nrec_ff + 16'd1;
   assign end_sum  = lrs_pkg::ADDR_BYTES + nrec_ff[15:8] + nrec_ff[7:0];

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      sum_in    = sum_ff;
      left_in   = left_ff;
      nrec_in   = nrec_ff;
      s9seen_in = s9seen_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      push_cmd  = '{kind: lrs_pkg::CMD_ERR, word: 16'd0, val8: 8'd0, cksum: 8'd0,
                    fin: 1'b0, status: lrs_pkg::ST_OK, bad_type: 8'd0,
                    offset: 24'd0};

      if (accept && phase_ff != lrs_pkg::PH_STOPPED && phase_ff != lrs_pkg::PH_DONE) begin
         if (req_end_of_input) begin
            push = 1'b1;
            if (phase_ff != lrs_pkg::PH_IDLE) begin
               push_cmd.status = lrs_pkg::ST_END_IN_REC;
               push_cmd.offset = pos_ff;
               phase_in        = lrs_pkg::PH_STOPPED;
            end else begin
               push_cmd.kind  = lrs_pkg::CMD_END;
               push_cmd.word  = nrec_ff;
               push_cmd.val8  = lrs_pkg::ADDR_BYTES;
               push_cmd.cksum = ~end_sum;
               push_cmd.fin   = !s9seen_ff;
               phase_in       = lrs_pkg::PH_DONE;
            end
         end else begin
            if (pos_ff != lrs_pkg::POS_MAX) begin
               pos_in = pos_ff + 24'd1;
            end
            case (phase_ff)
               lrs_pkg::PH_IDLE: begin
                  if (b == lrs_pkg::TYPE_DATA) begin
                     kind_in  = 1'b0;
                     phase_in = lrs_pkg::PH_ADDR_HI;
                  end else if (b == lrs_pkg::TYPE_START) begin
                     kind_in  = 1'b1;
                     phase_in = lrs_pkg::PH_ADDR_HI;
                  end else if (b != 8'd0) begin
                     push              = 1'b1;
                     push_cmd.status   = lrs_pkg::ST_BAD_TYPE;
                     push_cmd.bad_type = b;
                     push_cmd.offset   = pos_ff;
                     phase_in          = lrs_pkg::PH_STOPPED;
                  end
               end
               lrs_pkg::PH_ADDR_HI: begin
                  addr_in  = {b, 8'd0};
                  sum_in   = b;
                  phase_in = lrs_pkg::PH_ADDR_LO;
               end
               lrs_pkg::PH_ADDR_LO: begin
                  addr_in = {addr_ff[15:8], b};
                  if (kind_ff) begin
                     push           = 1'b1;
                     push_cmd.kind  = lrs_pkg::CMD_S9;
                     push_cmd.word  = {addr_ff[15:8], b};
                     push_cmd.val8  = lrs_pkg::ADDR_BYTES;
                     push_cmd.cksum = ~s_b3;
                     push_cmd.fin   = 1'b1;
                     sum_in         = s_b3;
                     s9seen_in      = 1'b1;
                     phase_in       = lrs_pkg::PH_IDLE;
                  end else begin
                     sum_in   = s_b;
                     phase_in = lrs_pkg::PH_COUNT;
                  end
               end
               lrs_pkg::PH_COUNT: begin
                  push = 1'b1;
                  if (b > lrs_pkg::MAX_COUNT) begin
                     push_cmd.status = lrs_pkg::ST_COUNT_BIG;
                     push_cmd.offset = pos_ff;
                     phase_in        = lrs_pkg::PH_STOPPED;
                  end else begin
                     push_cmd.kind  = lrs_pkg::CMD_S1;
                     push_cmd.word  = addr_ff;
                     push_cmd.val8  = cnt3;
                     push_cmd.cksum = ~s_b3;
                     push_cmd.fin   = (b == 8'd0);
                     sum_in         = s_b3;
                     left_in        = b;
                     if (b == 8'd0) begin
                        nrec_in  = nrec_inc;
                        phase_in = lrs_pkg::PH_IDLE;
                     end else begin
                        phase_in = lrs_pkg::PH_DATA;
                     end
                  end
               end
               lrs_pkg::PH_DATA: begin
                  push           = 1'b1;
                  push_cmd.kind  = lrs_pkg::CMD_DATA;
                  push_cmd.val8  = b;
                  push_cmd.cksum = ~s_b;
                  push_cmd.fin   = (left_ff == 8'd1);
                  sum_in         = s_b;
                  left_in        = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     nrec_in  = nrec_inc;
                     phase_in = lrs_pkg::PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lrs_pkg::PH_IDLE;
         kind_ff   <= 1'b0;
         addr_ff   <= 16'd0;
         sum_ff    <= 8'd0;
         left_ff   <= 8'd0;
         nrec_ff   <= 16'd0;
         s9seen_ff <= 1'b0;
         pos_ff    <= 24'd0;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         addr_ff   <= addr_in;
         sum_ff    <= sum_in;
         left_ff   <= left_in;
         nrec_ff   <= nrec_in;
         s9seen_ff <= s9seen_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// ===== rtl/lrs_queue.sv =====
// Short command queue between the front end and the text generator.
`timescale 1ns / 1ps

module lrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrs_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output lrs_pkg::cmd_type  head_cmd
);

   lrs_pkg::cmd_type store_ff [lrs_pkg::QDEPTH];

   logic [lrs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lrs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lrs_pkg::QCNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full       = (count_ff == lrs_pkg::QCNT_W'(lrs_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lrs_pkg::QPTR_W'(lrs_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lrs_pkg::QPTR_W'(lrs_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/lrs_back.sv =====
// Back end: expands queued commands into S-record characters, one per cycle while the output is not stalled.
`timescale 1ns / 1ps

module lrs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  lrs_pkg::cmd_type  head_cmd,
   output logic              pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [6:0]        rsp_out_char,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_bad_type,
   output logic [23:0]       rsp_error_offset,
   output logic              rsp_last
);

   logic [lrs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [6:0]  char_ff;
   logic [1:0]  status_ff;
   logic [7:0]  bad_ff;
   logic [23:0] offset_ff;
   logic        last_ff;

   logic                      load;
   logic                      take;
   logic [lrs_pkg::IDX_W-1:0] last_idx;
   logic                      at_last;
   logic                      second;
   logic [lrs_pkg::IDX_W-1:0] j;
   logic [6:0]                digit;
   logic [15:0]               word;
   logic [7:0]                ck;
   logic [6:0]                rec_char;
   logic [6:0]                ch;

   assign load    = !valid_ff || !rsp_stall;
   assign take    = load && head_valid;
   assign at_last = (idx_ff == last_idx);
   assign pop     = take && at_last;

   always_comb begin
      case (head_cmd.kind)
         lrs_pkg::CMD_S9:   last_idx = 5'd10;
         lrs_pkg::CMD_S1:   last_idx = head_cmd.fin ? 5'd10 : 5'd7;
         lrs_pkg::CMD_DATA: last_idx = head_cmd.fin ? 5'd4 : 5'd1;
         lrs_pkg::CMD_END:  last_idx = head_cmd.fin ? 5'd21 : 5'd10;
         default:           last_idx = 5'd0;
      endcase
   end

   // The trailing null start record reuses the record layout
   always_comb begin
      second = (head_cmd.kind == lrs_pkg::CMD_END) && (idx_ff >= 5'd11);
      j      = second ? (idx_ff - 5'd11) : idx_ff;
      word   = second ? 16'd0 : head_cmd.word;
      ck     = second ? lrs_pkg::NULL_S9_CK : head_cmd.cksum;
      if (second || head_cmd.kind == lrs_pkg::CMD_S9) begin
         digit = lrs_pkg::CH_9;
      end else if (head_cmd.kind == lrs_pkg::CMD_S1) begin
         digit = lrs_pkg::CH_1;
      end else begin
         digit = lrs_pkg::CH_5;
      end
      case (j)
         5'd0:    rec_char = lrs_pkg::CH_S;
         5'd1:    rec_char = digit;
         5'd2:    rec_char = lrs_pkg::hex_char(head_cmd.val8[7:4]);
         5'd3:    rec_char = lrs_pkg::hex_char(head_cmd.val8[3:0]);
         5'd4:    rec_char = lrs_pkg::hex_char(word[15:12]);
         5'd5:    rec_char = lrs_pkg::hex_char(word[11:8]);
         5'd6:    rec_char = lrs_pkg::hex_char(word[7:4]);
         5'd7:    rec_char = lrs_pkg::hex_char(word[3:0]);
         5'd8:    rec_char = lrs_pkg::hex_char(ck[7:4]);
         5'd9:    rec_char = lrs_pkg::hex_char(ck[3:0]);
         5'd10:   rec_char = lrs_pkg::CH_NL;
         default: rec_char = lrs_pkg::CH_NUL;
      endcase
   end

   always_comb begin
      case (head_cmd.kind)
         lrs_pkg::CMD_DATA: begin
            case (idx_ff)
               5'd0:    ch = lrs_pkg::hex_char(head_cmd.val8[7:4]);
               5'd1:    ch = lrs_pkg::hex_char(head_cmd.val8[3:0]);
               5'd2:    ch = lrs_pkg::hex_char(head_cmd.cksum[7:4]);
               5'd3:    ch = lrs_pkg::hex_char(head_cmd.cksum[3:0]);
               5'd4:    ch = lrs_pkg::CH_NL;
               default: ch = lrs_pkg::CH_NUL;
            endcase
         end
         lrs_pkg::CMD_ERR: ch = lrs_pkg::CH_NUL;
         default:          ch = rec_char;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (take) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff   <= ch;
         status_ff <= head_cmd.status;
         bad_ff    <= head_cmd.bad_type;
         offset_ff <= head_cmd.offset;
         last_ff   <= at_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_status       = status_ff;
   assign rsp_bad_type     = bad_ff;
   assign rsp_error_offset = offset_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/load_records_to_srecord_text.sv =====
// Top level: binary load file to S-record text encoder.
// The first character of a transaction's text passes the command queue, then the output register.
// Throughput: one character per cycle while the text port does not stall; a data byte gives two
// characters, an S1 header eight, a closed record three more, and end of input eleven or twenty-two.
// A four-entry command queue lets input run ahead by up to four text-producing transactions.
// Reset is synchronous, active high, and clears parser state, queue and output register.
`timescale 1ns / 1ps

module load_records_to_srecord_text (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_out_char,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_bad_type,
   output logic [23:0] rsp_error_offset,
   output logic        rsp_last
);

   // Front to queue
   logic             push;
   lrs_pkg::cmd_type push_cmd;
   logic             q_full;

   // Queue to back
   logic             head_valid;
   lrs_pkg::cmd_type head_cmd;
   logic             pop;

   // Hold input whenever the queue has no free slot; every accepted
   // transaction produces at most one command.
   assign req_stall = q_full;

   // Parse bytes, track record state, and turn each transaction into at most one command
   lrs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // Decouple parsing from text generation
   lrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Expand commands into characters, advancing one character per free output slot
   lrs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_status       (rsp_status),
      .rsp_bad_type     (rsp_bad_type),
      .rsp_error_offset (rsp_error_offset),
      .rsp_last         (rsp_last)
   );

   // An error is always a transaction's one and only result
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lrs_pkg::ST_OK |-> rsp_last && rsp_out_char == lrs_pkg::CH_NUL)
      else $error("error result not a lone result");

   // Text results carry no error information
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lrs_pkg::ST_OK |->
         rsp_bad_type == 8'd0 && rsp_error_offset == 24'd0)
      else $error("text result with error fields set");

   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into full queue");

   // A pop only happens when the output slot takes a character
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_last)
      else $error("command retired without last character");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the load file to S-record text encoder.
`timescale 1ns / 1ps

module testbench;
   import lrs_pkg::*;

   // One character (or error report) leaving the text port
   typedef struct packed {
      logic [6:0]  out_char;
      logic [1:0]  status;
      logic [7:0]  bad_type;
      logic [23:0] error_offset;
      logic        last;
   } text_item_t;

   // Scoreboard: tracks the encoder state, predicts the text for every accepted
   // input transaction and checks each text transaction against the oldest prediction.
   class srec_scoreboard;
      phase_type   phase;
      logic        is_start_rec;
      logic [15:0] load_addr;
      logic [7:0]  cksum_acc;
      logic [7:0]  data_left;
      logic [15:0] data_recs;
      logic        start_seen;
      logic [23:0] byte_pos;
      text_item_t  expected_text[$];
      text_item_t  fresh[$];
      int          mismatches;

      function new();
         phase        = PH_IDLE;
         is_start_rec = 1'b0;
         load_addr    = '0;
         cksum_acc    = '0;
         data_left    = '0;
         data_recs    = '0;
         start_seen   = 1'b0;
         byte_pos     = '0;
         mismatches   = 0;
      endfunction

      function void add_result(logic [6:0] ch, logic [1:0] st, logic [7:0] bad,
                               logic [23:0] off);
         text_item_t t;
         t.out_char     = ch;
         t.status       = st;
         t.bad_type     = bad;
         t.error_offset = off;
         t.last         = 1'b0;
         fresh.push_back(t);
      endfunction

      function void add_char(logic [6:0] ch);
         add_result(ch, ST_OK, 8'h00, 24'h000000);
      endfunction

      function void add_hex8(logic [7:0] v);
         string digits;
         digits = "0123456789ABCDEF";
         add_char(7'(digits[v[7:4]]));
         add_char(7'(digits[v[3:0]]));
      endfunction

      function void add_hex16(logic [15:0] v);
         add_hex8(v[15:8]);
         add_hex8(v[7:0]);
      endfunction

      function void close_record();
         add_hex8(~cksum_acc);
         add_char(CH_NL);
      endfunction

      function void count_data_record();
         if (data_recs != NREC_MAX) data_recs++;
      endfunction

      function void raise_error(logic [1:0] st, logic [7:0] bad, logic [23:0] off);
         add_result(CH_NUL, st, bad, off);
         phase = PH_STOPPED;
      endfunction

      function void take_byte(logic [7:0] b, logic [23:0] here);
         case (phase)
            PH_IDLE: begin
               if (b == TYPE_DATA) begin
                  is_start_rec = 1'b0;
                  phase        = PH_ADDR_HI;
               end else if (b == TYPE_START) begin
                  is_start_rec = 1'b1;
                  phase        = PH_ADDR_HI;
               end else if (b != 8'h00) begin
                  raise_error(ST_BAD_TYPE, b, here);
               end
            end
            PH_ADDR_HI: begin
               load_addr = {b, 8'h00};
               cksum_acc = b;
               phase     = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
               load_addr[7:0] = b;
               cksum_acc      = cksum_acc + b;
               if (is_start_rec) begin
                  cksum_acc = cksum_acc + ADDR_BYTES;
                  add_char(CH_S);
                  add_char(CH_9);
                  add_hex8(ADDR_BYTES);
                  add_hex16(load_addr);
                  close_record();
                  start_seen = 1'b1;
                  phase      = PH_IDLE;
               end else begin
                  phase = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (b > MAX_COUNT) begin
                  raise_error(ST_COUNT_BIG, 8'h00, here);
               end else begin
                  cksum_acc = cksum_acc + b + ADDR_BYTES;
                  add_char(CH_S);
                  add_char(CH_1);
                  add_hex8(b + ADDR_BYTES);
                  add_hex16(load_addr);
                  data_left = b;
                  if (b == 8'h00) begin
                     close_record();
                     count_data_record();
                     phase = PH_IDLE;
                  end else begin
                     phase = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               cksum_acc = cksum_acc + b;
               add_hex8(b);
               data_left = data_left - 8'd1;
               if (data_left == 8'h00) begin
                  close_record();
                  count_data_record();
                  phase = PH_IDLE;
               end
            end
            default: ;
         endcase
      endfunction

      function void end_of_file();
         logic [7:0] ck;
         if (phase != PH_IDLE) begin
            raise_error(ST_END_IN_REC, 8'h00, byte_pos);
            return;
         end
         ck = ADDR_BYTES + data_recs[15:8] + data_recs[7:0];
         add_char(CH_S);
         add_char(CH_5);
         add_hex8(ADDR_BYTES);
         add_hex16(data_recs);
         add_hex8(~ck);
         add_char(CH_NL);
         if (!start_seen) begin
            add_char(CH_S);
            add_char(CH_9);
            add_hex8(ADDR_BYTES);
            add_hex16(16'h0000);
            add_hex8(NULL_S9_CK);
            add_char(CH_NL);
         end
         phase = PH_DONE;
      endfunction

      // Note one accepted input transaction and queue the text it causes.
      function void note_input(logic [7:0] b, logic eoi);
         logic [23:0] here;
         fresh.delete();
         if (phase == PH_STOPPED || phase == PH_DONE) return;
         if (eoi) begin
            end_of_file();
         end else begin
            here = byte_pos;
            if (byte_pos != POS_MAX) byte_pos++;
            take_byte(b, here);
         end
         if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) expected_text.push_back(fresh[i]);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      // Check one accepted text transaction against the oldest prediction.
      function void check_result(text_item_t got);
         text_item_t want;
         if (expected_text.size() == 0) begin
            $error("unexpected transaction: out_char %0h status %0h offset %0h",
                   got.out_char, got.status, got.error_offset);
            mismatches++;
            return;
         end
         want = expected_text.pop_front();
         compare_field("out_char", want.out_char, got.out_char);
         compare_field("status", want.status, got.status);
         compare_field("bad_type", want.bad_type, got.bad_type);
         compare_field("error_offset", want.error_offset, got.error_offset);
         compare_field("last", want.last, got.last);
      endfunction

      function int pending();
         return expected_text.size();
      endfunction
   endclass

   // Receiver hold-off window, counted in cycles after reset
   localparam int HOLD_START = 300;
   localparam int HOLD_LEN   = 250;
   localparam int RECORD_ITEMS = 440;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte      = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [6:0]  rsp_out_char;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_bad_type;
   logic [23:0] rsp_error_offset;
   logic        rsp_last;

   srec_scoreboard sb = new();
   bit  no_idle = 1'b0;
   int  record_items = 0;

   load_records_to_srecord_text dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_status       (rsp_status),
      .rsp_bad_type     (rsp_bad_type),
      .rsp_error_offset (rsp_error_offset),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one transaction, with an occasional idle gap first, and hold it
   // until the block takes it. Valid stays high into the next call.
   task automatic send_item(input logic [7:0] b, input logic eoi = 1'b0);
      if (!no_idle && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      sb.note_input(b, eoi);
   endtask

   task automatic send_zero_run(input int n);
      repeat (n) send_item(8'h00);
   endtask

   // Data record with random payload
   task automatic send_data_record(input logic [15:0] addr, input int count);
      send_item(TYPE_DATA);
      send_item(addr[15:8]);
      send_item(addr[7:0]);
      send_item(8'(count));
      repeat (count) send_item(8'($urandom));
      record_items += count + 4;
   endtask

   task automatic send_start_record(input logic [15:0] addr);
      send_item(TYPE_START);
      send_item(addr[15:8]);
      send_item(addr[7:0]);
      record_items += 3;
   endtask

   // Cut a record short, then end the file inside it
   task automatic send_broken_record();
      logic [7:0] kind;
      int         cut;
      int         count;
      kind = $urandom_range(1) ? TYPE_DATA : TYPE_START;
      send_item(kind);
      cut = $urandom_range(0, (kind == TYPE_DATA) ? 3 : 1);
      if (cut >= 1) send_item(8'($urandom));
      if (cut >= 2) send_item(8'($urandom));
      if (cut == 3) begin
         count = $urandom_range(1, 20);
         send_item(8'(count));
         repeat ($urandom_range(0, count - 1)) send_item(8'($urandom));
      end
      send_item(8'($urandom), 1'b1);
   endtask

   function automatic int pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(0, 12);
      if (r < 97) return $urandom_range(13, 40);
      return $urandom_range(41, MAX_COUNT);
   endfunction

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: random stall, a calm stretch, and one long hold-off so that
   // the command queue fills and the input side stalls.
   initial begin
      int cyc;
      cyc = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 16);
         end
      end
   end

   // Monitor: sample accepted text transactions at the edge
   always @(posedge clock) begin
      text_item_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_char     = rsp_out_char;
         got.status       = rsp_status;
         got.bad_type     = rsp_bad_type;
         got.error_offset = rsp_error_offset;
         got.last         = rsp_last;
         sb.check_result(got);
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      bit         use_start;
      bit         max_done;
      int         r;
      int         ending;
      logic [7:0] b;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pick whether S9 records appear at all; without them the end of file
      // must append the null start record.
      use_start = $urandom_range(1);

      // Directed: skipped zeros, empty record, extreme address and data,
      // start records at both address extremes.
      send_zero_run(2);
      send_data_record(16'h0000, 0);
      send_item(TYPE_DATA);
      send_item(8'hFF);
      send_item(8'hFF);
      send_item(8'd2);
      send_item(8'hFF);
      send_item(8'h00);
      send_zero_run(1);
      if (use_start) begin
         send_start_record(16'h0000);
         send_start_record(16'hFFFF);
      end
      send_item(TYPE_DATA);
      send_item(8'h12);
      send_item(8'h34);
      send_item(8'd2);
      send_item(8'h80);
      send_item(8'h7F);
      record_items += 6;

      // Random: mostly well-formed records, some zero padding between them.
      // Drop idling for a stretch in the middle, across the longest record.
      max_done = 1'b0;
      while (record_items < RECORD_ITEMS) begin
         r = $urandom_range(99);
         if (!max_done && record_items > 60) begin
            no_idle = 1'b1;
            send_data_record(pick_addr(), MAX_COUNT);
            no_idle  = 1'b0;
            max_done = 1'b1;
         end else if (r < 70) begin
            send_data_record(pick_addr(), pick_count());
         end else if (r < 80 && use_start) begin
            send_start_record(pick_addr());
         end else begin
            send_zero_run($urandom_range(1, 3));
         end
      end
      no_idle = 1'b0;

      // Terminate the file: normal end, end inside a record, unknown type,
      // or an oversized count.
      ending = $urandom_range(99);
      if (ending < 55) begin
         send_item(8'($urandom), 1'b1);
      end else if (ending < 70) begin
         send_broken_record();
      end else if (ending < 85) begin
         do b = 8'($urandom);
         while (b == 8'h00 || b == TYPE_DATA || b == TYPE_START);
         send_item(b);
      end else begin
         send_item(TYPE_DATA);
         send_item(8'($urandom));
         send_item(8'($urandom));
         send_item(8'($urandom_range(MAX_COUNT + 1, 255)));
      end

      // The block is finished now; these must produce nothing.
      repeat (4) send_item(8'($urandom), 1'($urandom));
      req_valid <= 1'b0;

      // Drain, then allow time for any stray text to show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
